/* rtl/tdl_pkg.sv */
// Types and constants shared by the term/document literal parser.
`timescale 1ns / 1ps
package tdl_pkg;
   localparam logic [3:0] PH_BETWEEN    = 4'd0;
   localparam logic [3:0] PH_TERM       = 4'd1;
   localparam logic [3:0] PH_ESC        = 4'd2;
   localparam logic [3:0] PH_AFTER_QUOTE = 4'd3;
   localparam logic [3:0] PH_TF_FIRST   = 4'd4;
   localparam logic [3:0] PH_TF_DIGITS  = 4'd5;
   localparam logic [3:0] PH_POS_FIRST  = 4'd6;
   localparam logic [3:0] PH_POS_DIGITS = 4'd7;
   localparam logic [3:0] PH_POS_DONE   = 4'd8;

   localparam logic [1:0] CMP_EQ = 2'd0;
   localparam logic [1:0] CMP_LT = 2'd1;
   localparam logic [1:0] CMP_GT = 2'd2;

   localparam logic [2:0] K_BYTE   = 3'd0;
   localparam logic [2:0] K_END    = 3'd1;
   localparam logic [2:0] K_POS    = 3'd2;
   localparam logic [2:0] K_OK     = 3'd3;
   localparam logic [2:0] K_NONCAN = 3'd4;
   localparam logic [2:0] K_ERR    = 3'd5;

   localparam logic [4:0] E_NONE       = 5'd0;
   localparam logic [4:0] E_QUOTE      = 5'd1;
   localparam logic [4:0] E_UNTERM     = 5'd2;
   localparam logic [4:0] E_BSLASH     = 5'd3;
   localparam logic [4:0] E_COLON      = 5'd4;
   localparam logic [4:0] E_TF_DIGIT   = 5'd5;
   localparam logic [4:0] E_TF_RANGE   = 5'd6;
   localparam logic [4:0] E_MIXED      = 5'd7;
   localparam logic [4:0] E_FEW_POS    = 5'd8;
   localparam logic [4:0] E_POS_DIGIT  = 5'd9;
   localparam logic [4:0] E_POS_RANGE  = 5'd10;
   localparam logic [4:0] E_MANY_POS   = 5'd11;
   localparam logic [4:0] E_TRAILING   = 5'd12;
   localparam logic [4:0] E_TF_ZERO    = 5'd13;
   localparam logic [4:0] E_TERM_ORDER = 5'd14;
   localparam logic [4:0] E_POS_ORDER  = 5'd15;
   localparam logic [4:0] E_TOO_LONG   = 5'd16;

   localparam logic [30:0] TF_MAX  = 31'h7fffffff;
   localparam logic [30:0] POS_MAX = 31'h3fffffff;

   typedef struct packed {
      logic [2:0]  kind;
      logic [30:0] value;
      logic [1:0]  label;
      logic [4:0]  error_code;
      logic        last;
   } rsp_type;

   function automatic logic [2:0] label_of(input logic [7:0] c);
      case (c)
         8'h44:   label_of = 3'b100;
         8'h43:   label_of = 3'b101;
         8'h42:   label_of = 3'b110;
         8'h41:   label_of = 3'b111;
         default: label_of = 3'b000;
      endcase
   endfunction
endpackage

/* rtl/tdl_if.sv */
// Valid/ready channel interfaces for the parser.
`timescale 1ns / 1ps
interface tdl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface tdl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [30:0] value;
   logic [1:0]  label;
   logic [4:0]  error_code;
   logic        last;
   modport source (output valid, output kind, output value, output label,
                   output error_code, output last, input ready);
   modport sink (input valid, input kind, input value, input label,
                 input error_code, input last, output ready);
endinterface

/* rtl/tdl_term_ram.sv */
// Previous-term byte store, one write and one registered read port.
`timescale 1ns / 1ps
module tdl_term_ram #(
   parameter int DEPTH = 256,
   parameter int AW = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

/* rtl/tdl_out_queue.sv */
// Small result queue that decouples the parser from the result channel.
`timescale 1ns / 1ps
module tdl_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_n,
   input  tdl_pkg::rsp_type   push0,
   input  tdl_pkg::rsp_type   push1,
   output logic               room,
   tdl_rsp_if.source          rsp
);
   import tdl_pkg::*;

   rsp_type     q_ff [4];
   logic [1:0]  rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        pop;

   assign pop  = rsp.valid && rsp.ready;
   assign room = (cnt_ff <= 3'd2) || (cnt_ff == 3'd3 && pop);
   assign rsp.valid      = cnt_ff != 3'd0;
   assign rsp.kind       = q_ff[rd_ff].kind;
   assign rsp.value      = q_ff[rd_ff].value;
   assign rsp.label      = q_ff[rd_ff].label;
   assign rsp.error_code = q_ff[rd_ff].error_code;
   assign rsp.last       = q_ff[rd_ff].last;

   always_comb begin
      rd_in  = rd_ff + {1'b0, pop};
      wr_in  = wr_ff + push_n;
      cnt_in = cnt_ff + {1'b0, push_n} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_ff + 2'd1] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

/* rtl/tdl_parse_core.sv */
// Parse state machine with term compare against the byte store.
`timescale 1ns / 1ps
module tdl_parse_core #(
   parameter int MAX_TERM_LEN = 256,
   parameter int AW = 8,
   parameter int LW = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [7:0]       ch,
   input  logic [7:0]       rd_data,
   output logic             rd_en,
   output logic [AW-1:0]    rd_addr,
   output logic             wr_en,
   output logic [AW-1:0]    wr_addr,
   output logic [7:0]       wr_data,
   output logic [1:0]       push_n,
   output tdl_pkg::rsp_type push0,
   output tdl_pkg::rsp_type push1
);
   import tdl_pkg::*;

   logic [3:0]  ph_ff, ph_in;
   logic        seen_ff, seen_in, hasp_ff, hasp_in, lackp_ff, lackp_in;
   logic [30:0] num_ff, num_in, tf_ff, tf_in, npos_ff, npos_in;
   logic [29:0] prevo_ff, prevo_in;
   logic [LW-1:0] plen_ff, plen_in, clen_ff, clen_in;
   logic [1:0]  cmp_ff, cmp_in;
   logic [4:0]  terr_ff, terr_in;
   logic        oerr_ff, oerr_in, halt_ff, halt_in;
   logic        rearm;
   logic        digit;
   logic [3:0]  d;
   logic [34:0] nxt;
   logic [2:0]  lab;

   rsp_type r [2];
   logic [1:0] n;

   assign digit = ch >= 8'h30 && ch <= 8'h39;
   assign d     = digit ? ch[3:0] : 4'd0;
   assign nxt   = {num_ff, 3'b0} + {2'b0, num_ff, 1'b0} + {31'b0, d};
   assign lab   = label_of(ch);

   assign rd_en   = go;
   assign rd_addr = clen_in[AW-1:0];

   always_comb begin
      logic [7:0] p;
      logic       fin_req, tail_sp;
      p       = rd_data;
      fin_req = 1'b0;
      tail_sp = 1'b0;
      ph_in = ph_ff; seen_in = seen_ff; hasp_in = hasp_ff; lackp_in = lackp_ff;
      num_in = num_ff; tf_in = tf_ff; npos_in = npos_ff; prevo_in = prevo_ff;
      plen_in = plen_ff; clen_in = clen_ff; cmp_in = cmp_ff; terr_in = terr_ff;
      oerr_in = oerr_ff; halt_in = halt_ff; rearm = 1'b0;
      wr_en = 1'b0; wr_addr = clen_ff[AW-1:0]; wr_data = ch;
      n = 2'd0;
      r[0] = '0; r[1] = '0;
      if (halt_ff) begin
         if (ch == 8'd0) rearm = 1'b1;
      end else begin
         case (ph_ff)
            PH_BETWEEN: begin
               if (ch == 8'd0) fin_req = 1'b1;
               else if (ch == 8'h27) begin
                  clen_in = '0; cmp_in = CMP_EQ; ph_in = PH_TERM;
               end else if (ch != 8'h20) begin
                  r[0] = fail_r(E_QUOTE); n = 2'd1; halt_in = 1'b1;
               end
            end
            PH_TERM, PH_ESC: begin
               if (ch == 8'd0) begin
                  r[0] = fail_r(ph_ff == PH_TERM ? E_UNTERM : E_BSLASH);
                  n = 2'd1; rearm = 1'b1;
               end else if (ph_ff == PH_TERM && ch == 8'h5c) ph_in = PH_ESC;
               else if (ph_ff == PH_TERM && ch == 8'h27) begin
                  plen_in = clen_ff; ph_in = PH_AFTER_QUOTE;
               end else begin
                  ph_in = PH_TERM;
                  if (clen_ff >= LW'(MAX_TERM_LEN)) begin
                     r[0] = fail_r(E_TOO_LONG); n = 2'd1; halt_in = 1'b1;
                  end else begin
                     if (cmp_ff == CMP_EQ) begin
                        if (clen_ff < plen_ff) begin
                           if (p < ch) cmp_in = CMP_GT;
                           else if (p > ch) cmp_in = CMP_LT;
                        end else cmp_in = CMP_GT;
                     end
                     wr_en = 1'b1;
                     clen_in = clen_ff + 1'b1;
                     r[0].kind = K_BYTE; r[0].value = {23'b0, ch}; n = 2'd1;
                  end
               end
            end
            PH_AFTER_QUOTE: begin
               if (ch == 8'h3a) ph_in = PH_TF_FIRST;
               else begin r[0] = fail_r(E_COLON); n = 2'd1; fail_end(); end
            end
            PH_TF_FIRST, PH_POS_FIRST: begin
               if (digit) begin
                  num_in = {27'b0, d};
                  ph_in = ph_ff == PH_TF_FIRST ? PH_TF_DIGITS : PH_POS_DIGITS;
               end else begin
                  r[0] = fail_r(ph_ff == PH_TF_FIRST ? E_TF_DIGIT : E_POS_DIGIT);
                  n = 2'd1; fail_end();
               end
            end
            PH_TF_DIGITS: begin
               if (digit) begin
                  if (nxt > {4'b0, TF_MAX}) begin
                     r[0] = fail_r(E_TF_RANGE); n = 2'd1; fail_end();
                  end else num_in = nxt[30:0];
               end else begin
                  tf_in = num_ff;
                  r[0].kind = K_END; r[0].value = num_ff; n = 2'd1;
                  if (terr_ff == E_NONE) begin
                     if (num_ff == 31'd0) terr_in = E_TF_ZERO;
                     else if (seen_ff && cmp_ff != CMP_GT) terr_in = E_TERM_ORDER;
                  end
                  seen_in = 1'b1;
                  if (ch == 8'h40) begin
                     if (lackp_ff) begin
                        r[1] = fail_r(E_MIXED); n = 2'd2; fail_end();
                     end else begin
                        hasp_in = 1'b1; npos_in = '0;
                        ph_in = num_ff == 31'd0 ? PH_POS_DONE : PH_POS_FIRST;
                     end
                  end else if (hasp_ff) begin
                     r[1] = fail_r(E_MIXED); n = 2'd2; fail_end();
                  end else begin
                     lackp_in = 1'b1; tail_sp = 1'b1;
                  end
               end
            end
            PH_POS_DIGITS: begin
               if (digit) begin
                  if (nxt > {4'b0, POS_MAX}) begin
                     r[0] = fail_r(E_POS_RANGE); n = 2'd1; fail_end();
                  end else num_in = nxt[30:0];
               end else begin
                  if (npos_ff != 31'd0 && num_ff <= {1'b0, prevo_ff}) oerr_in = 1'b1;
                  prevo_in = num_ff[29:0];
                  npos_in = npos_ff + 1'b1;
                  r[0].kind = K_POS; r[0].value = num_ff; r[0].label = lab[1:0];
                  n = 2'd1;
                  ph_in = PH_POS_DONE;
                  if (!lab[2]) pos_done(npos_ff + 1'b1, tail_sp);
               end
            end
            PH_POS_DONE: pos_done(npos_ff, tail_sp);
            default: rearm = 1'b1;
         endcase
         if (tail_sp) begin
            if (ch == 8'h20) ph_in = PH_BETWEEN;
            else if (ch == 8'd0) fin_req = 1'b1;
            else begin r[n[0]] = fail_r(E_TRAILING); n = n + 2'd1; fail_end(); end
         end
         if (fin_req) begin
            if (!seen_in) r[n[0]].kind = K_NONCAN;
            else if (terr_in != E_NONE) begin
               r[n[0]].kind = K_ERR; r[n[0]].error_code = terr_in;
            end else if (oerr_in) begin
               r[n[0]].kind = K_ERR; r[n[0]].error_code = E_POS_ORDER;
            end else r[n[0]].kind = K_OK;
            n = n + 2'd1;
            rearm = 1'b1;
         end
      end
      if (n == 2'd1) r[0].last = 1'b1;
      if (n == 2'd2) r[1].last = 1'b1;
   end

   function automatic rsp_type fail_r(input logic [4:0] code);
      rsp_type t;
      t = '0;
      if (code <= E_TF_DIGIT && !seen_in) t.kind = K_NONCAN;
      else begin t.kind = K_ERR; t.error_code = code; end
      return t;
   endfunction

   function automatic void fail_end();
      if (ch == 8'd0) rearm = 1'b1;
      else halt_in = 1'b1;
   endfunction

   function automatic void pos_done(input logic [30:0] cnt, inout logic tail);
      if (cnt < tf_ff) begin
         if (ch == 8'h2c) ph_in = PH_POS_FIRST;
         else begin r[n[0]] = fail_r(E_FEW_POS); n = n + 2'd1; fail_end(); end
      end else if (ch == 8'h2c) begin
         r[n[0]] = fail_r(E_MANY_POS); n = n + 2'd1; fail_end();
      end else tail = 1'b1;
   endfunction

   assign push_n = go ? n : 2'd0;
   assign push0  = r[0];
   assign push1  = r[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_BETWEEN; seen_ff <= 1'b0; hasp_ff <= 1'b0; lackp_ff <= 1'b0;
         num_ff <= '0; tf_ff <= '0; npos_ff <= '0; prevo_ff <= '0;
         plen_ff <= '0; clen_ff <= '0; cmp_ff <= CMP_EQ; terr_ff <= '0;
         oerr_ff <= 1'b0; halt_ff <= 1'b0;
      end else if (go) begin
         if (rearm) begin
            ph_ff <= PH_BETWEEN; seen_ff <= 1'b0; hasp_ff <= 1'b0; lackp_ff <= 1'b0;
            num_ff <= '0; tf_ff <= '0; npos_ff <= '0; prevo_ff <= '0;
            plen_ff <= '0; clen_ff <= '0; cmp_ff <= CMP_EQ; terr_ff <= '0;
            oerr_ff <= 1'b0; halt_ff <= 1'b0;
         end else begin
            ph_ff <= ph_in; seen_ff <= seen_in; hasp_ff <= hasp_in;
            lackp_ff <= lackp_in; num_ff <= num_in; tf_ff <= tf_in;
            npos_ff <= npos_in; prevo_ff <= prevo_in; plen_ff <= plen_in;
            clen_ff <= clen_in; cmp_ff <= cmp_in; terr_ff <= terr_in;
            oerr_ff <= oerr_in; halt_ff <= halt_in;
         end
      end
   end
endmodule

/* rtl/term_doc_literal_parser.sv */
// Top level of the term/document literal parser.
//  channel | dir | payload
//  req     | in  | ch[7:0]
//  rsp     | out | kind, value, label, error_code, last
// One character per cycle; the term compare reads the next byte of the
// previous term from the store ahead of its use (registered read port).
// Synchronous reset clears parse state; the byte store is not cleared.
// req stalls only when the four-entry result queue has no room for two.
`timescale 1ns / 1ps
module term_doc_literal_parser #(
   parameter int MAX_TERM_LEN = 256
) (
   input  logic      clock,
   input  logic      reset,
   tdl_req_if.sink   req,
   tdl_rsp_if.source rsp
);
   import tdl_pkg::*;

   localparam int AW = $clog2(MAX_TERM_LEN);
   localparam int LW = $clog2(MAX_TERM_LEN + 1);

   logic          go, room, rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    rd_data, wr_data;
   logic [1:0]    push_n;
   rsp_type       push0, push1;

   assign req.ready = room;
   assign go        = req.valid && room;

   tdl_term_ram #(.DEPTH(MAX_TERM_LEN), .AW(AW)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data
   );

   tdl_parse_core #(.MAX_TERM_LEN(MAX_TERM_LEN), .AW(AW), .LW(LW)) u_core (
      .clock, .reset, .go, .ch(req.ch), .rd_data, .rd_en, .rd_addr,
      .wr_en, .wr_addr, .wr_data, .push_n, .push0, .push1
   );

   tdl_out_queue u_q (
      .clock, .reset, .push_n, .push0, .push1, .room, .rsp
   );
endmodule
